/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define EWC_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define EWC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* design/ewc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ewc_pkg;

   localparam int DATA_W   = 16;
   localparam int FRAC_W   = DATA_W / 2;
   localparam int LANES    = 4;
   localparam int MAG_W    = 16;
   localparam int WPROD_W  = 2 * DATA_W;
   localparam int OP_W     = 2;
   localparam int CNT_W    = 3;
   localparam int IDX_W    = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [OP_W-1:0] OP_PROD     = 2'd0;
   localparam logic [OP_W-1:0] OP_SUM      = 2'd1;
   localparam logic [OP_W-1:0] OP_MAX      = 2'd2;
   localparam logic [OP_W-1:0] OP_PROD_INC = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_OPERATION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUTS_USED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_0    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_1    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_2    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_3    = 3'd5;

   localparam logic [OP_W-1:0]         OPERATION_RST   = OP_SUM;
   localparam logic [CNT_W-1:0]        INPUTS_USED_RST = 3'd2;
   localparam logic signed [DATA_W-1:0] WEIGHT_RST     = 16'sd256;
   localparam logic signed [DATA_W:0]  ONE_Q           = 17'sd256;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

   typedef struct packed {
      logic                       active;
      logic                       neg;
      logic [MAG_W-1:0]           mag;
      logic signed [WPROD_W-1:0]  wprod;
      logic signed [DATA_W-1:0]   elem;
   } ewc_lane_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      shift_sel;
   } ewc_ctrl_type;

endpackage

`default_nettype wire

/* design/ewc_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module ewc_lane import ewc_pkg::*; (
   input  wire logic                       clock,
   input  wire logic signed [DATA_W-1:0]   elem,
   input  wire logic signed [DATA_W-1:0]   weight,
   input  wire logic [OP_W-1:0]            op,
   input  wire logic                       active,
   output ewc_lane_type                    lane_ff
);

   logic signed [DATA_W:0]   factor;
   logic [DATA_W:0]          factor_abs;
   logic signed [WPROD_W-1:0] wprod;
   ewc_lane_type             lane_in;

   always_comb begin
      if (op == OP_PROD_INC) begin
         factor = {elem[DATA_W-1], elem} + ONE_Q;
      end else begin
         factor = {elem[DATA_W-1], elem};
      end
      factor_abs = factor[DATA_W] ? (DATA_W+1)'(-factor) : (DATA_W+1)'(factor);
      wprod = WPROD_W'(weight) * WPROD_W'(elem);

      lane_in.active = active;
      lane_in.elem   = elem;
      if (active) begin
         lane_in.neg   = factor[DATA_W];
         lane_in.mag   = factor_abs[MAG_W-1:0];
         lane_in.wprod = wprod;
      end else begin
         lane_in.neg   = 1'b0;
         lane_in.mag   = MAG_W'(1);
         lane_in.wprod = '0;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

endmodule

`default_nettype wire

/* design/ewc_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module ewc_merge import ewc_pkg::*; (
   input  wire logic                      clock,
   input  wire ewc_lane_type              lanes [LANES],
   input  wire ewc_ctrl_type              ctrl,
   output logic signed [DATA_W-1:0]       combined_ff,
   output logic [IDX_W-1:0]               winner_ff
);

   // pair stage
   logic [2*MAG_W-1:0]          m01_ff, m23_ff;
   logic                        n01_ff, n23_ff;
   logic signed [WPROD_W:0]     s01_ff, s23_ff;
   logic signed [DATA_W-1:0]    x01_ff, x23_ff;
   logic [IDX_W-1:0]            i01_ff, i23_ff;
   logic                        v23_ff;
   ewc_ctrl_type                ctrl_a_ff;
   logic signed [DATA_W-1:0]    x01_in, x23_in;
   logic [IDX_W-1:0]            i01_in, i23_in;

   // combine stage
   logic [4*MAG_W-1:0]          prod_ff;
   logic                        pneg_ff;
   logic signed [WPROD_W+1:0]   sum_ff;
   logic signed [DATA_W-1:0]    xmax_ff;
   logic [IDX_W-1:0]            imax_ff;
   ewc_ctrl_type                ctrl_b_ff;
   logic signed [DATA_W-1:0]    xmax_in;
   logic [IDX_W-1:0]            imax_in;

   // rounding stage
   logic [4*MAG_W-FRAC_W-1:0]   prod_shift;
   logic                        prod_half;
   logic [4*MAG_W-FRAC_W:0]     prod_rnd;
   logic signed [DATA_W-1:0]    prod_res;
   logic signed [WPROD_W+2:0]   sum_biased;
   logic signed [WPROD_W+2-FRAC_W:0] sum_q;
   logic signed [DATA_W-1:0]    sum_res;
   logic signed [DATA_W-1:0]    combined_in;
   logic [IDX_W-1:0]            winner_in;

   always_comb begin
      if (lanes[0].elem > lanes[1].elem) begin
         x01_in = lanes[0].elem;
         i01_in = IDX_W'(0);
      end else begin
         x01_in = lanes[1].elem;
         i01_in = IDX_W'(1);
      end
      if (lanes[3].active && (lanes[3].elem > lanes[2].elem)) begin
         x23_in = lanes[3].elem;
         i23_in = IDX_W'(3);
      end else begin
         x23_in = lanes[2].elem;
         i23_in = IDX_W'(2);
      end
   end

   always_ff @(posedge clock) begin
      m01_ff    <= lanes[0].mag * lanes[1].mag;
      m23_ff    <= lanes[2].mag * lanes[3].mag;
      n01_ff    <= lanes[0].neg ^ lanes[1].neg;
      n23_ff    <= lanes[2].neg ^ lanes[3].neg;
      s01_ff    <= (WPROD_W+1)'($signed(lanes[0].wprod)) + (WPROD_W+1)'($signed(lanes[1].wprod));
      s23_ff    <= (WPROD_W+1)'($signed(lanes[2].wprod)) + (WPROD_W+1)'($signed(lanes[3].wprod));
      x01_ff    <= x01_in;
      i01_ff    <= i01_in;
      x23_ff    <= x23_in;
      i23_ff    <= i23_in;
      v23_ff    <= lanes[2].active;
      ctrl_a_ff <= ctrl;
   end

   // later pair wins only when strictly greater
   always_comb begin
      if (v23_ff && (x23_ff > x01_ff)) begin
         xmax_in = x23_ff;
         imax_in = i23_ff;
      end else begin
         xmax_in = x01_ff;
         imax_in = i01_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= (4*MAG_W)'(m01_ff) * (4*MAG_W)'(m23_ff);
      pneg_ff   <= n01_ff ^ n23_ff;
      sum_ff    <= (WPROD_W+2)'(s01_ff) + (WPROD_W+2)'(s23_ff);
      xmax_ff   <= xmax_in;
      imax_ff   <= imax_in;
      ctrl_b_ff <= ctrl_a_ff;
   end

   always_comb begin
      unique case (ctrl_b_ff.shift_sel)
         2'd2: begin
            prod_shift = (4*MAG_W-FRAC_W)'(prod_ff[4*MAG_W-1:2*FRAC_W]);
            prod_half  = prod_ff[2*FRAC_W-1];
         end
         2'd3: begin
            prod_shift = (4*MAG_W-FRAC_W)'(prod_ff[4*MAG_W-1:3*FRAC_W]);
            prod_half  = prod_ff[3*FRAC_W-1];
         end
         default: begin
            prod_shift = prod_ff[4*MAG_W-1:FRAC_W];
            prod_half  = prod_ff[FRAC_W-1];
         end
      endcase
      prod_rnd = {1'b0, prod_shift} + (4*MAG_W-FRAC_W+1)'(prod_half);

      if (pneg_ff) begin
         if (prod_rnd > (4*MAG_W-FRAC_W+1)'(32768)) begin
            prod_res = SAT_MIN;
         end else begin
            prod_res = -$signed(prod_rnd[DATA_W-1:0]);
         end
      end else begin
         if (prod_rnd > (4*MAG_W-FRAC_W+1)'(32767)) begin
            prod_res = SAT_MAX;
         end else begin
            prod_res = $signed(prod_rnd[DATA_W-1:0]);
         end
      end

      // ties away from zero: bias one less below zero, then floor
      sum_biased = {sum_ff[WPROD_W+1], sum_ff}
                   + (sum_ff[WPROD_W+1] ? (WPROD_W+3)'(127) : (WPROD_W+3)'(128));
      sum_q = sum_biased[WPROD_W+2:FRAC_W];
      if (sum_q > (WPROD_W+3-FRAC_W)'(signed'(SAT_MAX))) begin
         sum_res = SAT_MAX;
      end else if (sum_q < (WPROD_W+3-FRAC_W)'(signed'(SAT_MIN))) begin
         sum_res = SAT_MIN;
      end else begin
         sum_res = sum_q[DATA_W-1:0];
      end

      unique case (ctrl_b_ff.op)
         OP_SUM: begin
            combined_in = sum_res;
            winner_in   = '0;
         end
         OP_MAX: begin
            combined_in = xmax_ff;
            winner_in   = imax_ff;
         end
         default: begin
            combined_in = prod_res;
            winner_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      combined_ff <= combined_in;
      winner_ff   <= winner_in;
   end

endmodule

`default_nettype wire

/* design/elementwise_combine_core.sv */
// Elementwise combiner: folds the same-position Q8.8 elements of up to four
// tensors into one saturated Q8.8 value (product, weighted sum, maximum with
// winning index, or product of x plus one).
// Input: an item is taken on a rising edge with start high and busy low.
// busy is high only while reset is held and for the cycle after it; from
// then on every cycle can take a new item.
// Output: each result appears on rsp_combined / rsp_winner_index for one
// cycle with rsp_valid high, registered through the lane, pair, combine
// and rounding stages; results leave in order.
// Throughput is one item per cycle: four lane multipliers, then a pair
// stage, a combine stage (one 32x32 product) and a rounding stage.
// The receiver has no back-pressure; results are simply presented.
// Registers: csr_valid/csr_ready write csr_wdata to register csr_index
// (0 operation, 1 inputs used, 2..5 weights); unknown indices are dropped.
// Write registers only with no transaction in flight.
// Reset: synchronous, clears the pipeline valids and loads register defaults
// (weighted sum, two inputs, all weights 1.0).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module elementwise_combine_core import ewc_pkg::*; #(
   parameter int MAX_INPUTS = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [DATA_W-1:0]  req_elem_0,
   input  wire logic signed [DATA_W-1:0]  req_elem_1,
   input  wire logic signed [DATA_W-1:0]  req_elem_2,
   input  wire logic signed [DATA_W-1:0]  req_elem_3,
   output logic                           rsp_valid,
   output logic signed [DATA_W-1:0]       rsp_combined,
   output logic [IDX_W-1:0]               rsp_winner_index,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [DATA_W-1:0]         csr_wdata
);

   localparam int LANE_NUM = (MAX_INPUTS < LANES) ? MAX_INPUTS : LANES;

   logic                      busy_ff;
   logic [OP_W-1:0]           operation_ff;
   logic [CNT_W-1:0]          inputs_used_ff;
   logic signed [DATA_W-1:0]  weight_ff [LANES];
   logic [CNT_W-1:0]          lane_count;
   logic [LANES-1:0]          lane_active;
   logic signed [DATA_W-1:0]  elem_vec [LANES];
   ewc_lane_type              lane_s1 [LANES];
   ewc_ctrl_type              ctrl_in, ctrl_s1_ff;
   logic [2:0]                valid_ff;
   logic                      rsp_valid_ff;
   logic                      accept;
   logic                      csr_write;

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;
   assign accept    = start & ~busy_ff;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         operation_ff   <= OPERATION_RST;
         inputs_used_ff <= INPUTS_USED_RST;
         for (int i = 0; i < LANES; i++) begin
            weight_ff[i] <= WEIGHT_RST;
         end
      end else begin
         busy_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               REG_OPERATION:   operation_ff   <= csr_wdata[OP_W-1:0];
               REG_INPUTS_USED: inputs_used_ff <= csr_wdata[CNT_W-1:0];
               REG_WEIGHT_0:    weight_ff[0]   <= csr_wdata;
               REG_WEIGHT_1:    weight_ff[1]   <= csr_wdata;
               REG_WEIGHT_2:    weight_ff[2]   <= csr_wdata;
               REG_WEIGHT_3:    weight_ff[3]   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      if (inputs_used_ff < CNT_W'(2)) begin
         lane_count = CNT_W'(2);
      end else if (inputs_used_ff > CNT_W'(LANE_NUM)) begin
         lane_count = CNT_W'(LANE_NUM);
      end else begin
         lane_count = inputs_used_ff;
      end
      for (int i = 0; i < LANES; i++) begin
         lane_active[i] = CNT_W'(i) < lane_count;
      end
      ctrl_in.op = operation_ff;
      if ((operation_ff == OP_PROD) || (operation_ff == OP_PROD_INC)) begin
         ctrl_in.shift_sel = 2'(lane_count - CNT_W'(1));
      end else begin
         ctrl_in.shift_sel = 2'd1;
      end
   end

   assign elem_vec[0] = req_elem_0;
   assign elem_vec[1] = req_elem_1;
   assign elem_vec[2] = req_elem_2;
   assign elem_vec[3] = req_elem_3;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      if (g < LANE_NUM) begin : g_used
         ewc_lane u_lane (
            .clock   (clock),
            .elem    (elem_vec[g]),
            .weight  (weight_ff[g]),
            .op      (operation_ff),
            .active  (lane_active[g]),
            .lane_ff (lane_s1[g])
         );
      end else begin : g_unused
         assign lane_s1[g] = '{active: 1'b0, neg: 1'b0, mag: MAG_W'(1),
                               wprod: '0, elem: elem_vec[g]};
      end
   end

   always_ff @(posedge clock) begin
      ctrl_s1_ff <= ctrl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[1:0], accept};
         rsp_valid_ff <= valid_ff[2];
      end
   end

   ewc_merge u_merge (
      .clock       (clock),
      .lanes       (lane_s1),
      .ctrl        (ctrl_s1_ff),
      .combined_ff (rsp_combined),
      .winner_ff   (rsp_winner_index)
   );

   assign rsp_valid = rsp_valid_ff;

   `EWC_ASSERT_NEXT(a_latency, accept, ##3 rsp_valid, "accepted transaction lost")
   `EWC_ASSERT_IMPLY(a_index_mode, rsp_valid && (operation_ff != OP_MAX),
                     rsp_winner_index == '0, "winner index set outside max mode")
   `EWC_ASSERT_IMPLY(a_index_range, rsp_valid && (operation_ff == OP_MAX),
                     {1'b0, rsp_winner_index} < lane_count, "winner lane not in use")

endmodule

`default_nettype wire

/* tb/elementwise_combine_checker.sv */
`timescale 1ns / 1ps

module elementwise_combine_checker import ewc_pkg::*; #(
   parameter int MAX_INPUTS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic signed [DATA_W-1:0]   req_elem_0,
   input  logic signed [DATA_W-1:0]   req_elem_1,
   input  logic signed [DATA_W-1:0]   req_elem_2,
   input  logic signed [DATA_W-1:0]   req_elem_3,
   input  logic                       rsp_valid,
   input  logic signed [DATA_W-1:0]   rsp_combined,
   input  logic [IDX_W-1:0]           rsp_winner_index,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [DATA_W-1:0]          csr_wdata,
   output int                         mismatch_count,
   output int                         awaited_count,
   output int                         compared_count
);

   localparam int LANE_LIMIT = (MAX_INPUTS < LANES) ? MAX_INPUTS : LANES;
   localparam longint unsigned POS_LIMIT = 64'(SAT_MAX);

   typedef struct packed {
      logic signed [DATA_W-1:0] combined;
      logic [IDX_W-1:0]         winner_index;
   } combined_result_type;

   logic [OP_W-1:0]          op_mode;
   logic [CNT_W-1:0]         lanes_cfg;
   logic signed [DATA_W-1:0] lane_weight [LANES];
   combined_result_type      awaited_results [$];
   int                       mismatch_total = 0;
   int                       awaited_total = 0;
   int                       compared_total = 0;

   assign mismatch_count = mismatch_total;
   assign awaited_count  = awaited_total;
   assign compared_count = compared_total;

   // nearest, ties away from zero, then clamp to the signed Q8.8 range
   function automatic logic signed [DATA_W-1:0] round_saturate(input bit neg,
         input longint unsigned mag, input int unsigned sh);
      longint unsigned          r;
      logic signed [DATA_W-1:0] v;
      r = (mag >> sh) + ((mag >> (sh - 1)) & 64'd1);
      v = r[DATA_W-1:0];
      if (neg) begin
         if (r > POS_LIMIT + 1) return SAT_MIN;
         return -v;
      end
      if (r > POS_LIMIT) return SAT_MAX;
      return v;
   endfunction

   function automatic combined_result_type combine_elements(
         input logic signed [DATA_W-1:0] e0, input logic signed [DATA_W-1:0] e1,
         input logic signed [DATA_W-1:0] e2, input logic signed [DATA_W-1:0] e3);
      logic signed [DATA_W-1:0] x [LANES];
      logic signed [DATA_W-1:0] best;
      int unsigned              n;
      longint                   f;
      longint                   acc;
      longint unsigned          mag;
      longint unsigned          factor;
      bit                       neg;
      combined_result_type      res;
      x[0] = e0;
      x[1] = e1;
      x[2] = e2;
      x[3] = e3;
      n = (lanes_cfg < 2) ? 2 : ((lanes_cfg > LANE_LIMIT) ? LANE_LIMIT : lanes_cfg);
      res = '0;
      case (op_mode)
         OP_PROD, OP_PROD_INC: begin
            neg = 1'b0;
            mag = 1;
            for (int i = 0; i < n; i++) begin
               f = x[i];
               if (op_mode == OP_PROD_INC) f = f + ONE_Q;
               if (f < 0) begin
                  neg = !neg;
                  factor = -f;
               end else begin
                  factor = f;
               end
               mag = mag * factor;
            end
            if (mag == 0) neg = 1'b0;
            res.combined = round_saturate(neg, mag, FRAC_W * (n - 1));
         end
         OP_SUM: begin
            acc = 0;
            for (int i = 0; i < n; i++) acc = acc + longint'(lane_weight[i]) * longint'(x[i]);
            if (acc < 0) res.combined = round_saturate(1'b1, -acc, FRAC_W);
            else res.combined = round_saturate(1'b0, acc, FRAC_W);
         end
         default: begin
            // lane 1 takes a tie with lane 0; later lanes must be strictly greater
            if (x[0] > x[1]) begin
               best = x[0];
               res.winner_index = IDX_W'(0);
            end else begin
               best = x[1];
               res.winner_index = IDX_W'(1);
            end
            for (int i = 2; i < n; i++) begin
               if (x[i] > best) begin
                  best = x[i];
                  res.winner_index = IDX_W'(i);
               end
            end
            res.combined = best;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      combined_result_type want;
      if (reset) begin
         op_mode = OPERATION_RST;
         lanes_cfg = INPUTS_USED_RST;
         foreach (lane_weight[i]) lane_weight[i] = WEIGHT_RST;
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: unexpected transaction, combined %h index %0d", $time,
                     rsp_combined, rsp_winner_index);
            end else begin
               want = awaited_results.pop_front();
               compared_total++;
               if (want.combined !== rsp_combined ||
                     want.winner_index !== rsp_winner_index) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display("%0t: combined exp %h got %h, index exp %0d got %0d", $time,
                        want.combined, rsp_combined, want.winner_index, rsp_winner_index);
               end
            end
         end
         if (start && !busy)
            awaited_results.push_back(combine_elements(req_elem_0, req_elem_1,
               req_elem_2, req_elem_3));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OPERATION: op_mode = csr_wdata[OP_W-1:0];
               REG_INPUTS_USED: lanes_cfg = csr_wdata[CNT_W-1:0];
               REG_WEIGHT_0: lane_weight[0] = csr_wdata;
               REG_WEIGHT_1: lane_weight[1] = csr_wdata;
               REG_WEIGHT_2: lane_weight[2] = csr_wdata;
               REG_WEIGHT_3: lane_weight[3] = csr_wdata;
               default: ;
            endcase
         end
      end
      awaited_total = awaited_results.size();
   end

endmodule

/* tb/elementwise_combine_core_test.sv */
`timescale 1ns / 1ps

module elementwise_combine_core_test;
   import ewc_pkg::*;

   localparam int TOTAL_ITEMS = 1350;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [DATA_W-1:0] req_elem_0;
   logic signed [DATA_W-1:0] req_elem_1;
   logic signed [DATA_W-1:0] req_elem_2;
   logic signed [DATA_W-1:0] req_elem_3;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_combined;
   logic [IDX_W-1:0]         rsp_winner_index;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DATA_W-1:0]        csr_wdata;

   int mismatch_count;
   int awaited_count;
   int compared_count;
   int items_sent = 0;
   int phase_count = 0;
   int cycle_count = 0;

   elementwise_combine_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_elem_0       (req_elem_0),
      .req_elem_1       (req_elem_1),
      .req_elem_2       (req_elem_2),
      .req_elem_3       (req_elem_3),
      .rsp_valid        (rsp_valid),
      .rsp_combined     (rsp_combined),
      .rsp_winner_index (rsp_winner_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   elementwise_combine_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_elem_0       (req_elem_0),
      .req_elem_1       (req_elem_1),
      .req_elem_2       (req_elem_2),
      .req_elem_3       (req_elem_3),
      .rsp_valid        (rsp_valid),
      .rsp_combined     (rsp_combined),
      .rsp_winner_index (rsp_winner_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .awaited_count    (awaited_count),
      .compared_count   (compared_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [DATA_W-1:0] rand_elem();
      case ($urandom_range(0, 9))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return DATA_W'($urandom_range(0, 2)) - DATA_W'(1);
         3, 4: return DATA_W'($urandom_range(0, 1023)) - DATA_W'(512);
         default: return DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_weight();
      case ($urandom_range(0, 9))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return WEIGHT_RST;
         3, 4, 5: return DATA_W'($urandom_range(0, 1023)) - DATA_W'(512);
         default: return DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] rand_lanes();
      case ($urandom_range(0, 9))
         0: return CNT_W'($urandom_range(0, 1));
         1: return CNT_W'($urandom_range(5, 7));
         default: return CNT_W'($urandom_range(2, 4));
      endcase
   endfunction

   task automatic send_item(input logic [DATA_W-1:0] e0, input logic [DATA_W-1:0] e1,
         input logic [DATA_W-1:0] e2, input logic [DATA_W-1:0] e3);
      @(negedge clock);
      start <= 1'b1;
      req_elem_0 <= e0;
      req_elem_1 <= e1;
      req_elem_2 <= e2;
      req_elem_3 <= e3;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic pause_input(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      req_elem_0 <= rand_elem();
      req_elem_1 <= rand_elem();
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // block idle before any write; upper bits of narrow registers carry noise
   task automatic set_config(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] lanes,
         input logic [DATA_W-1:0] w0, input logic [DATA_W-1:0] w1,
         input logic [DATA_W-1:0] w2, input logic [DATA_W-1:0] w3);
      logic [DATA_W-1:0] word;
      drain_results();
      repeat (6) @(negedge clock);
      word = DATA_W'($urandom_range(0, 65535));
      word[OP_W-1:0] = op;
      csr_write(REG_OPERATION, word);
      word = DATA_W'($urandom_range(0, 65535));
      word[CNT_W-1:0] = lanes;
      csr_write(REG_INPUTS_USED, word);
      csr_write(REG_WEIGHT_0, w0);
      csr_write(REG_WEIGHT_1, w1);
      csr_write(REG_WEIGHT_2, w2);
      csr_write(REG_WEIGHT_3, w3);
      if (phase_count % 3 == 0)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
            DATA_W'($urandom_range(0, 65535)));
      @(negedge clock);
      csr_valid <= 1'b0;
      phase_count++;
   endtask

   task automatic run_phase(input int count, input bit back_to_back);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         repeat (burst) send_item(rand_elem(), rand_elem(), rand_elem(), rand_elem());
         left -= burst;
         if (left > 0 && !back_to_back) begin
            case ($urandom_range(0, 7))
               0: drain_results();
               1, 2: ;
               default: pause_input($urandom_range(1, 8));
            endcase
         end
      end
   endtask

   initial begin
      int rand_phase;
      int count;
      logic [OP_W-1:0] op;
      logic [CNT_W-1:0] lanes;
      reset = 1'b1;
      start = 1'b0;
      req_elem_0 = '0;
      req_elem_1 = '0;
      req_elem_2 = '0;
      req_elem_3 = '0;
      csr_valid = 1'b0;
      csr_index = REG_OPERATION;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults after reset: weighted sum of two lanes at unit weight
      send_item(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN);
      send_item(SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX);
      send_item(16'h0001, 16'hffff, 16'h0000, 16'h0000);

      set_config(OP_SUM, 3'd4, SAT_MAX, SAT_MIN, 16'h0080, 16'hff80);
      send_item(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);
      send_item(16'h0001, 16'h0000, 16'h0001, 16'h0000);
      send_item(16'h0001, 16'h0001, 16'h0000, 16'h0000);

      // half-LSB products round away from zero
      set_config(OP_PROD, 3'd2, WEIGHT_RST, WEIGHT_RST, WEIGHT_RST, WEIGHT_RST);
      send_item(16'h0080, 16'h0001, SAT_MAX, SAT_MAX);
      send_item(16'hff80, 16'h0001, SAT_MAX, SAT_MAX);
      send_item(SAT_MIN, SAT_MIN, 16'h0000, 16'h0000);
      send_item(SAT_MIN, SAT_MAX, 16'h0000, 16'h0000);

      set_config(OP_PROD, 3'd4, WEIGHT_RST, WEIGHT_RST, WEIGHT_RST, WEIGHT_RST);
      send_item(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
      send_item(16'h0100, 16'h0100, 16'h0100, 16'hff00);
      send_item(16'h0000, SAT_MAX, SAT_MAX, SAT_MAX);

      // ties: lane 1 beats lane 0, later lanes need strictly greater
      set_config(OP_MAX, 3'd4, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX);
      send_item(16'h0005, 16'h0005, 16'h0005, 16'h0001);
      send_item(16'h0003, 16'h0002, 16'h0003, 16'h0004);
      send_item(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
      send_item(SAT_MAX, 16'h0000, SAT_MAX, 16'h0000);
      send_item(16'h0000, 16'h0000, 16'h0000, 16'h0001);

      // lane count below range counts as two, above as four
      set_config(OP_PROD_INC, 3'd0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
      send_item(16'hff00, SAT_MAX, 16'h0000, 16'h0000);
      send_item(SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX);
      set_config(OP_PROD_INC, 3'd7, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
      send_item(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
      send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);

      rand_phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (rand_phase < 12) begin
            op = OP_W'(rand_phase % 4);
            lanes = CNT_W'(2 + rand_phase % 3);
         end else begin
            op = OP_W'($urandom_range(0, 3));
            lanes = rand_lanes();
         end
         set_config(op, lanes, rand_weight(), rand_weight(), rand_weight(), rand_weight());
         count = $urandom_range(30, 90);
         if (count > TOTAL_ITEMS - items_sent) count = TOTAL_ITEMS - items_sent;
         run_phase(count, $urandom_range(0, 4) == 0);
         rand_phase++;
      end

      drain_results();
      repeat (8) @(negedge clock);
      $display("Sent %0d items over %0d register settings (all modes, lane counts 0..7,",
         items_sent, phase_count);
      $display("extreme weights and elements); %0d results compared.", compared_count);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* elementwise_combine_core.f */
+incdir+design
design/ewc_pkg.sv
design/ewc_lane.sv
design/ewc_merge.sv
design/elementwise_combine_core.sv
tb/elementwise_combine_checker.sv
tb/elementwise_combine_core_test.sv
